// File: hdl/aesbm_pkg.sv
// Package for the AES-128 block-mode encryptor.
// Holds the S-box, round helpers, mode codes and register indexes.
// No dependencies.
`default_nettype none

package aesbm_pkg;

    // Number of AES-128 rounds
    localparam int ROUNDS = 10;

    // Chaining modes; code 3 has no meaning and runs as ECB
    typedef enum logic [1:0] {
        CHAIN_ECB = 2'd0,
        CHAIN_CBC = 2'd1,
        CHAIN_CFB = 2'd2
    } mode_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_HIGH   = 3'd0,
        REG_KEY_LOW    = 3'd1,
        REG_IV_HIGH    = 3'd2,
        REG_IV_LOW     = 3'd3,
        REG_CHAIN_MODE = 3'd4
    } reg_index_t;

    // All round keys, index 0 is the whitening key
    typedef logic [ROUNDS:0][127:0] round_keys_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    // Byte i of a block sits at bits 127-8i down
    function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
        return b[127 - 8 * i -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes followed by ShiftRows
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                r[127 - 8 * (i + 4 * c) -: 8] =
                    SBOX[get_byte(s, i + 4 * ((c + i) % 4))];
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] r;
        logic [7:0]   a0, a1, a2, a3, all;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = get_byte(s, 4 * c);
            a1  = get_byte(s, 4 * c + 1);
            a2  = get_byte(s, 4 * c + 2);
            a3  = get_byte(s, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            r[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1),
                                     a1 ^ all ^ xtime(a1 ^ a2),
                                     a2 ^ all ^ xtime(a2 ^ a3),
                                     a3 ^ all ^ xtime(a3 ^ a0)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/aes128_block_mode_encrypt_top.sv
// Top level of the AES-128 ECB/CBC/CFB-128 encryptor.
// Depends on aesbm_pkg, aesbm_key_sched and aesbm_cipher.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata plaintext, s_tuser first_block
//  m_*       out        m_tvalid/m_tready  m_tdata ciphertext
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
// One item per cycle while the result side does not stall; an item passes
// the input register, one-pass cipher and result register. The chaining
// register closes the loop through the single-pass cipher, which sets the
// rate. Reset clears all registers and the chain value. Round keys follow
// a key write through the key and round-key registers. A stalled result
// holds and the input side keeps one item waiting behind it.
`default_nettype none

module aes128_block_mode_encrypt_top
    import aesbm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // plain_high [63:0], plain_low [127:64]
    input  wire logic         s_tuser,   // first_block
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata,   // cipher_high [63:0], cipher_low [127:64]
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    logic [63:0]  key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic [1:0]   mode_reg;
    logic [127:0] chain_reg, chain_next;
    logic         in_valid_reg, in_first_reg;
    logic [127:0] in_plain_reg;
    logic         out_valid_reg;
    logic [127:0] out_cipher_reg;

    round_keys_t  round_keys;
    logic [127:0] chain_src, aes_in, aes_out, cipher;
    logic         advance, use_cbc, use_cfb;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            mode_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_HIGH:   key_high_reg <= cfg_data;
                REG_KEY_LOW:    key_low_reg  <= cfg_data;
                REG_IV_HIGH:    iv_high_reg  <= cfg_data;
                REG_IV_LOW:     iv_low_reg   <= cfg_data;
                REG_CHAIN_MODE: mode_reg     <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    aesbm_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        ({key_high_reg, key_low_reg}),
        .round_keys (round_keys)
    );

    // Handshake: the input register moves on when the result slot is empty or is read out
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            in_first_reg <= 1'b0;
            in_plain_reg <= '0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
            in_first_reg <= s_tuser;
            in_plain_reg <= {s_tdata[63:0], s_tdata[127:64]};
        end
    end

    // Mode selection around the cipher
    assign use_cbc   = (mode_reg == CHAIN_CBC);
    assign use_cfb   = (mode_reg == CHAIN_CFB);
    assign chain_src = in_first_reg ? {iv_high_reg, iv_low_reg} : chain_reg;
    assign aes_in    = use_cbc ? (in_plain_reg ^ chain_src)
                     : use_cfb ? chain_src : in_plain_reg;

    aesbm_cipher u_cipher (
        .block_in   (aes_in),
        .round_keys (round_keys),
        .block_out  (aes_out)
    );

    assign cipher     = use_cfb ? (in_plain_reg ^ aes_out) : aes_out;
    // ECB keeps the chain, but a first block still loads the IV
    assign chain_next = (use_cbc || use_cfb) ? cipher : chain_src;

    // Chain value and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            chain_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_cipher_reg <= '0;
        end else begin
            if (advance) begin
                chain_reg      <= chain_next;
                out_cipher_reg <= cipher;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_cipher_reg[63:0], out_cipher_reg[127:64]};

    // Checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input side not ready while input register empty");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result lost after advance");

    a_blocked_means_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !s_tready) |-> (m_tvalid && !m_tready))
        else $error("input blocked without output stall");

    a_chain_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chain_reg))
        else $error("chain value changed without an item");

endmodule

`default_nettype wire

// File: hdl/aesbm_key_sched.sv
// AES-128 key expansion, registered.
// Uses aesbm_pkg for the S-box and round constants.
`default_nettype none

module aesbm_key_sched
    import aesbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [127:0] key,
    output round_keys_t      round_keys
);

    round_keys_t rk_reg;
    round_keys_t rk_next;

    // Expand the configured key one round word group at a time
    always_comb
    begin
        logic [31:0] w0, w1, w2, w3, t;
        rk_next[0] = key;
        for (int r = 1; r <= ROUNDS; r++) begin
            w0 = rk_next[r - 1][127:96];
            w1 = rk_next[r - 1][95:64];
            w2 = rk_next[r - 1][63:32];
            w3 = rk_next[r - 1][31:0];
            t  = {SBOX[w3[23:16]] ^ RCON[r - 1], SBOX[w3[15:8]],
                  SBOX[w3[7:0]], SBOX[w3[31:24]]};
            w0 = w0 ^ t;
            w1 = w1 ^ w0;
            w2 = w2 ^ w1;
            w3 = w3 ^ w2;
            rk_next[r] = {w0, w1, w2, w3};
        end
    end

    // Round keys are registered from the expanded key input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rk_reg <= '0;
        end else begin
            rk_reg <= rk_next;
        end
    end

    assign round_keys = rk_reg;

endmodule

`default_nettype wire

// File: hdl/aesbm_cipher.sv
// AES-128 encryption datapath, all ten rounds in one pass.
// Uses aesbm_pkg for the round functions.
`default_nettype none

module aesbm_cipher
    import aesbm_pkg::*;
(
    input  wire logic [127:0] block_in,
    input  round_keys_t       round_keys,
    output logic [127:0]      block_out
);

    // Whitening, nine full rounds, then the last round without MixColumns
    always_comb
    begin
        logic [127:0] s;
        s = block_in ^ round_keys[0];
        for (int r = 1; r < ROUNDS; r++) begin
            s = mix_columns(sub_shift(s)) ^ round_keys[r];
        end
        block_out = sub_shift(s) ^ round_keys[ROUNDS];
    end

endmodule

`default_nettype wire

// File: tb/tb_aes128_block_mode_encrypt_top.sv
// Testbench for the AES-128 ECB/CBC/CFB-128 block encryptor.
// Drives plaintext items from a queue and checks every ciphertext item.
// Depends on aesbm_pkg and aes128_block_mode_encrypt_top.
`timescale 1ns / 1ps

module tb_aes128_block_mode_encrypt_top
    import aesbm_pkg::*;
();

    typedef struct packed {
        logic        first;
        logic [63:0] ph;
        logic [63:0] pl;
    } plain_item_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_data;

    // Predictor state
    logic [127:0] key_q, iv_q;
    logic [127:0] chain_q = '0;
    logic [1:0]   mode_q;

    plain_item_t  pending_q[$];
    logic [127:0] cipher_q[$];
    int           errors = 0;
    int           gap_cnt, stall_cnt, idle_cycles;
    logic         in_taken, out_taken;

    localparam int IDLE_LIMIT = 2000;

    aes128_block_mode_encrypt_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ---- AES-128 written independently on byte arrays ----
    function automatic logic [7:0] gmul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes128_enc_block(input logic [127:0] k,
                                                      input logic [127:0] p);
        logic [7:0] w[176];
        logic [7:0] s[16];
        logic [7:0] t[16];
        logic [7:0] tmp[4];
        logic [7:0] f, a0, a1, a2, a3, x;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) w[i] = k[127 - 8 * i -: 8];
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) tmp[j] = w[4 * (i - 1) + j];
            if (i % 4 == 0) begin
                f = tmp[0];
                tmp[0] = SBOX[tmp[1]] ^ RCON[i / 4 - 1];
                tmp[1] = SBOX[tmp[2]];
                tmp[2] = SBOX[tmp[3]];
                tmp[3] = SBOX[f];
            end
            for (int j = 0; j < 4; j++) w[4 * i + j] = w[4 * (i - 4) + j] ^ tmp[j];
        end
        for (int i = 0; i < 16; i++) s[i] = p[127 - 8 * i -: 8] ^ w[i];
        for (int rd = 1; rd <= 10; rd++) begin
            for (int i = 0; i < 16; i++) t[i] = SBOX[s[i]];
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) s[i + 4 * c] = t[i + 4 * ((c + i) % 4)];
            if (rd != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4 * c]; a1 = s[4 * c + 1]; a2 = s[4 * c + 2]; a3 = s[4 * c + 3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    s[4 * c]     = a0 ^ x ^ gmul2(a0 ^ a1);
                    s[4 * c + 1] = a1 ^ x ^ gmul2(a1 ^ a2);
                    s[4 * c + 2] = a2 ^ x ^ gmul2(a2 ^ a3);
                    s[4 * c + 3] = a3 ^ x ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = s[i] ^ w[16 * rd + i];
        end
        for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
        return r;
    endfunction

    // Work out the ciphertext of one accepted item and advance the chain
    function automatic logic [127:0] predict_cipher(input plain_item_t it);
        logic [127:0] pt, ct;
        pt = {it.ph, it.pl};
        if (it.first) chain_q = iv_q;
        case (mode_q)
            CHAIN_CBC: begin ct = aes128_enc_block(key_q, pt ^ chain_q); chain_q = ct; end
            CHAIN_CFB: begin ct = pt ^ aes128_enc_block(key_q, chain_q); chain_q = ct; end
            default:   ct = aes128_enc_block(key_q, pt);
        endcase
        return ct;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_KEY_HIGH:   key_q[127:64] = val;
            REG_KEY_LOW:    key_q[63:0]   = val;
            REG_IV_HIGH:    iv_q[127:64]  = val;
            REG_IV_LOW:     iv_q[63:0]    = val;
            REG_CHAIN_MODE: mode_q        = val[1:0];
            default: ;
        endcase
    endtask

    // Unknown index: no effect on the predictor
    task automatic write_bad_index(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Checked just after the falling edge so the driver's updates are visible
    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || cipher_q.size() != 0) begin
            @(negedge clk);
            #1;
        end
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_edge64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    task automatic push_item(input logic first, input logic [63:0] ph, input logic [63:0] pl);
        plain_item_t it;
        it.first = first; it.ph = ph; it.pl = pl;
        pending_q.push_back(it);
    endtask

    // Handshakes seen at the rising edge, for the falling-edge drivers
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_taken  <= 1'b0;
            out_taken <= 1'b0;
        end else begin
            in_taken  <= s_tvalid && s_tready;
            out_taken <= m_tvalid && m_tready;
        end
    end

    // Driver: one pending item at a time, random gap after each
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            gap_cnt  <= 0;
        end else if (s_tvalid && !in_taken) begin
            // hold the item
        end else if (gap_cnt > 0) begin
            s_tvalid <= 1'b0;
            gap_cnt  <= gap_cnt - 1;
        end else if (pending_q.size() != 0) begin
            s_tvalid <= 1'b1;
            s_tdata  <= {pending_q[0].pl, pending_q[0].ph};
            s_tuser  <= pending_q[0].first;
            void'(pending_q.pop_front());
            gap_cnt  <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 5);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Result side stalls, drawn afresh after each accepted item
    always @(negedge clk) begin
        int w;
        if (!rst_n) begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (out_taken) w = $urandom_range(0, 5);
            else           w = stall_cnt;
            if (w > 0) begin
                m_tready  <= 1'b0;
                stall_cnt <= w - 1;
            end else begin
                m_tready  <= 1'b1;
                stall_cnt <= 0;
            end
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge clk) begin
        plain_item_t  it;
        logic [127:0] want;
        int           idle_next;
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_next = idle_cycles + 1;
            if (s_tvalid && s_tready) begin
                it.first = s_tuser; it.ph = s_tdata[63:0]; it.pl = s_tdata[127:64];
                cipher_q.push_back(predict_cipher(it));
                idle_next = 0;
            end
            if (m_tvalid && m_tready) begin
                idle_next = 0;
                if (cipher_q.size() == 0) begin
                    report_mismatch("unexpected item", m_tdata[63:0], '0);
                end else begin
                    want = cipher_q.pop_front();
                    if (m_tdata[63:0] !== want[127:64])
                        report_mismatch("cipher_high", m_tdata[63:0], want[127:64]);
                    if (m_tdata[127:64] !== want[63:0])
                        report_mismatch("cipher_low", m_tdata[127:64], want[63:0]);
                end
            end
            idle_cycles <= idle_next;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_aes128_block_mode_encrypt_top failed");
            $finish;
        end
    end

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        key_q = '0; iv_q = '0; mode_q = CHAIN_ECB;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: CBC with no first block yet chains from zero
        write_reg(REG_CHAIN_MODE, 64'(CHAIN_CBC));
        push_item(1'b0, '0, '0);
        push_item(1'b0, '1, '1);
        wait_drained();

        // FIPS-197 vector and field extremes in ECB
        write_reg(REG_KEY_HIGH, 64'h0001020304050607);
        write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
        write_reg(REG_IV_HIGH, '1);
        write_reg(REG_IV_LOW, 64'h0123456789abcdef);
        write_reg(REG_CHAIN_MODE, 64'(CHAIN_ECB));
        push_item(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
        push_item(1'b1, '0, '1);
        push_item(1'b0, '1, '0);
        wait_drained();

        // ECB ignores chain; first block still loads IV, then CFB uses it
        write_reg(REG_CHAIN_MODE, 64'(CHAIN_CFB));
        push_item(1'b0, 64'h1, 64'h2);
        push_item(1'b0, 64'h3, 64'h4);
        push_item(1'b1, 64'h5, 64'h6);
        wait_drained();

        // Mode three runs as ECB; unknown index ignored
        write_reg(REG_CHAIN_MODE, 64'h3);
        write_bad_index(3'd5, '1);
        write_bad_index(3'd7, '1);
        push_item(1'b1, 64'hdeadbeef, 64'hcafef00d);
        push_item(1'b0, '1, '1);
        wait_drained();

        // Mid-message: mode change keeps chain, IV only at next first block
        write_reg(REG_CHAIN_MODE, 64'(CHAIN_CBC));
        push_item(1'b1, rand64(), rand64());
        push_item(1'b0, rand64(), rand64());
        wait_drained();
        write_reg(REG_IV_HIGH, rand64());
        write_reg(REG_CHAIN_MODE, 64'(CHAIN_CFB));
        write_reg(REG_KEY_LOW, '1);
        push_item(1'b0, rand64(), rand64());
        push_item(1'b1, rand64(), rand64());
        wait_drained();

        // Random phases: messages with random content under varying settings
        for (int ph = 0; ph < 24; ph++) begin
            int n;
            write_reg(REG_KEY_HIGH, rand_edge64());
            write_reg(REG_KEY_LOW, rand_edge64());
            write_reg(REG_IV_HIGH, rand_edge64());
            write_reg(REG_IV_LOW, rand_edge64());
            write_reg(REG_CHAIN_MODE, 64'($urandom_range(0, 3)));
            n = 0;
            while (n < 75) begin
                int len;
                len = $urandom_range(1, 12);
                for (int b = 0; b < len; b++) begin
                    push_item(b == 0 ? 1'b1 : ($urandom_range(0, 15) == 0),
                              rand_edge64(), rand_edge64());
                    n++;
                end
            end
            if (ph == 10) begin
                // Hold the sender back until every ciphertext has arrived
                while (pending_q.size() != 0 || s_tvalid) @(negedge clk);
                while (cipher_q.size() != 0) @(negedge clk);
            end
            wait_drained();
        end

        wait_drained();
        if (errors == 0)
            $display("tb_aes128_block_mode_encrypt_top passed");
        else
            $display("tb_aes128_block_mode_encrypt_top failed");
        $finish;
    end

endmodule
